>>> hdl/msp_chk_pkg.sv
`timescale 1ns / 1ps

package msp_chk_pkg;

    localparam logic [7:0] SIG0 = 8'h24;
    localparam logic [7:0] SIG1 = 8'h4D;
    localparam logic [7:0] SIG2 = 8'h3E;
    localparam logic [8:0] FRAME_LAST_OFS = 9'd5;
    localparam logic [8:0] POS_SIG0 = 9'd0;
    localparam logic [8:0] POS_SIG1 = 9'd1;
    localparam logic [8:0] POS_SIG2 = 9'd2;
    localparam logic [8:0] POS_SIZE = 9'd3;
    localparam logic [8:0] POS_CODE = 9'd4;
    localparam logic [8:0] POS_PAYLOAD = 9'd5;

    localparam logic CFG_CODE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_SIG  = 3'd1,
        ST_SIZE = 3'd2,
        ST_CODE = 3'd3,
        ST_CSUM = 3'd4
    } t_status;

    typedef struct packed {
        logic [8:0] count;
        logic [7:0] xsum;
        t_status    err;
    } t_frame_state;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] index;
        logic       done;
        t_status    status;
    } t_result;

endpackage

>>> hdl/msp_chk_step.sv
`timescale 1ns / 1ps

module msp_chk_step
    import msp_chk_pkg::*;
(
    input  logic [7:0]   i_byte,
    input  t_frame_state i_state,
    input  logic [7:0]   i_exp_code,
    input  logic [7:0]   i_exp_size,
    output t_frame_state o_state,
    output logic         o_res_valid,
    output t_result      o_res
);

    logic [8:0] last_pos;
    logic [8:0] pay_pos;
    logic [7:0] xsum_upd;
    t_status    chk_err;

    assign last_pos = {1'b0, i_exp_size} + FRAME_LAST_OFS;
    assign pay_pos  = i_state.count - POS_PAYLOAD;
    assign xsum_upd = i_state.xsum ^ i_byte;

    // check outcome of this byte, before the first-error rule
    always_comb begin
        chk_err = ST_OK;
        if (i_state.count >= last_pos) begin
            if (i_byte != i_state.xsum) chk_err = ST_CSUM;
        end else begin
            unique case (i_state.count)
                POS_SIG0: if (i_byte != SIG0) chk_err = ST_SIG;
                POS_SIG1: if (i_byte != SIG1) chk_err = ST_SIG;
                POS_SIG2: if (i_byte != SIG2) chk_err = ST_SIG;
                POS_SIZE: if (i_byte != i_exp_size) chk_err = ST_SIZE;
                POS_CODE: if (i_byte != i_exp_code) chk_err = ST_CODE;
                default:  chk_err = ST_OK;
            endcase
        end
    end

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{data: 8'd0, index: 8'd0, done: 1'b0, status: ST_OK};
        if (i_state.count >= last_pos) begin
            o_state     = '{count: 9'd0, xsum: 8'd0, err: ST_OK};
            o_res_valid = 1'b1;
            o_res.done  = 1'b1;
            o_res.status = (i_state.err != ST_OK) ? i_state.err : chk_err;
        end else begin
            o_state.count = i_state.count + 9'd1;
            if (i_state.err == ST_OK) o_state.err = chk_err;
            if (i_state.count >= POS_SIZE) o_state.xsum = xsum_upd;
            if ((i_state.count >= POS_PAYLOAD) && (i_state.err == ST_OK)) begin
                o_res_valid = 1'b1;
                o_res.data  = i_byte;
                o_res.index = pay_pos[7:0];
            end
        end
    end

endmodule

>>> hdl/msp_response_frame_checker.sv
`timescale 1ns / 1ps

// Checks one MSP v1 response frame ('$','M','>', size, code, payload, checksum),
// exactly expected_size+6 bytes long, taking one received byte per cycle while the
// input stall is low, with no gaps of its own. Each payload word is passed on through
// the output register (through the skid stage first while the output is stalled), with
// its index, until the first error; the last byte of the frame yields a status word
// with frame_done set (0 ok, 1 signature, 2 size, 3 code, 4 checksum). A one-word
// skid stage lets input keep flowing while the output is stalled, and the input
// stall rises only once that stage is occupied. Register writes take effect on
// the next byte, also mid-frame; a size that puts the frame end at or below the
// current position makes the next byte the checksum byte.
module msp_response_frame_checker
    import msp_chk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_byte_index,
    output logic       o_frame_done,
    output logic [2:0] o_status
);

    logic [7:0]   r_exp_code;
    logic [7:0]   r_exp_size;
    t_frame_state r_state;
    t_frame_state n_state;
    logic         step_res_valid;
    t_result      step_res;
    logic         r_out_valid;
    t_result      r_out;
    logic         r_skid_valid;
    t_result      r_skid;
    logic         rx_take;
    logic         out_free;

    assign o_rx_stall = r_skid_valid;
    assign rx_take    = i_rx_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_res_stall;

    msp_chk_step u_step (
        .i_byte      (i_rx_byte),
        .i_state     (r_state),
        .i_exp_code  (r_exp_code),
        .i_exp_size  (r_exp_size),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_code <= 8'd0;
            r_exp_size <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CODE: r_exp_code <= i_cfg_data;
                CFG_SIZE: r_exp_size <= i_cfg_data;
                default:  r_exp_code <= r_exp_code;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{count: 9'd0, xsum: 8'd0, err: ST_OK};
        end else if (rx_take) begin
            r_state <= n_state;
        end
    end

    // output register with one-word skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= rx_take && step_res_valid;
                end
            end else if (rx_take && step_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : step_res;
        end
        if (!out_free && rx_take && step_res_valid) begin
            r_skid <= step_res;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_out_byte   = r_out.data;
    assign o_byte_index = r_out.index;
    assign o_frame_done = r_out.done;
    assign o_status     = r_out.status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_payload_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done) |-> (r_out.status == ST_OK))
        else $error("payload word carries a status code");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= (9'd255 + FRAME_LAST_OFS))
        else $error("frame position past the longest frame");

    a_no_payload_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_take && (r_state.err != ST_OK) && step_res_valid) |-> step_res.done)
        else $error("payload passed on after an error");

endmodule
